// ----- hdl/rtpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpc_pkg
// Shared types, constants and helpers of the range to prefix cover block.
// ----------------------------------------------------------------------------
package rtpc_pkg;

  localparam int WIDTH    = 32;
  localparam int FIELD_W  = 32;
  localparam int LEN_W    = 6;

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam len_t P_MAX = LEN_W'(WIDTH);

  // one result beat
  typedef struct packed {
    field_t base;
    len_t   length;
    logic   last;
  } beat_t;

  // low q bits set, q from 0 to WIDTH
  function automatic word_t low_mask(input len_t q);
    logic [WIDTH:0] one_hot;
    logic [WIDTH:0] m;
    one_hot = (WIDTH+1)'(1) << q;
    m       = one_hot - (WIDTH+1)'(1);
    return m[WIDTH-1:0];
  endfunction

  // two's complement field to offset binary word
  function automatic word_t to_offset(input field_t v);
    word_t w;
    w = v[WIDTH-1:0];
    w[WIDTH-1] = ~w[WIDTH-1];
    return w;
  endfunction

endpackage

// ----- hdl/rtpc_fit_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpc_fit_unit
// Shared test: does an aligned block of 2^q words at lower stay within end.
// ----------------------------------------------------------------------------
module rtpc_fit_unit import rtpc_pkg::*; (
  input  word_t lower,
  input  word_t bound,
  input  len_t  q,
  output logic  fit
);

  word_t mask;

  assign mask = low_mask(q);
  assign fit  = ((lower & mask) == '0) && ((lower | mask) <= bound);

endmodule

// ----- hdl/rtpc_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpc_out_reg
// Output register stage holding one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rtpc_out_reg import rtpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  beat_t beat_in,
  input  logic  out_stall,
  output logic  out_valid,
  output beat_t beat,
  output logic  free
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      beat <= beat_in;
    end
  end

endmodule

// ----- hdl/range_to_prefix_cover_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_to_prefix_cover_core
// Splits an inclusive signed range into the smallest ascending prefix cover.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry range_start and range_end, both
// two's complement; the bounds are mapped to offset binary on accept.
// Output channel: out_valid / out_stall carry one prefix per beat
// (prefix_base, prefix_length, last_prefix), ascending, last one marked.
// An empty range (start above end) is taken and gives no beat.
// One range is worked at a time; in_stall stays high until its last prefix
// is loaded into the output register.
// A single fit unit tests one candidate prefix size per cycle, save while a
// found prefix waits on a stalled output: the size grows one bit a cycle
// and shrinks one bit a cycle, and each emitted prefix is followed by a
// retest of the same size at the next lower bound.
// A stalled output holds its beat; the sequencer then waits at its next emit.
// Reset (rst, synchronous) drops the range in work and any held beat.
// ----------------------------------------------------------------------------
module range_to_prefix_cover_core import rtpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  field_t range_start,
  input  field_t range_end,
  output logic   out_valid,
  input  logic   out_stall,
  output field_t prefix_base,
  output len_t   prefix_length,
  output logic   last_prefix
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;
  word_t  lower;
  word_t  bound;
  len_t   p;
  logic   p_ok;

  len_t   q;
  logic   fit;
  word_t  filled;
  logic   done;
  logic   emit;
  logic   out_free;
  beat_t  beat_in;
  beat_t  beat;
  word_t  start_ob;
  word_t  end_ob;

  assign in_stall = (state != IDLE);
  assign start_ob = to_offset(range_start);
  assign end_ob   = to_offset(range_end);

  // with p_ok the current size is known to fit, so try one bit more
  assign q = p_ok ? p + len_t'(1) : p;

  rtpc_fit_unit u_fit (
    .lower (lower),
    .bound (bound),
    .q     (q),
    .fit   (fit)
  );

  assign filled = lower | low_mask(p);
  // filled never passes the end, so reaching it is equality
  assign done   = (filled == bound);
  assign emit   = (state == RUN) && p_ok && ((p == P_MAX) || !fit);

  assign beat_in.base   = FIELD_W'(lower);
  assign beat_in.length = P_MAX - p;
  assign beat_in.last   = done;

  rtpc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .beat_in   (beat_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .beat      (beat),
    .free      (out_free)
  );

  assign prefix_base   = beat.base;
  assign prefix_length = beat.length;
  assign last_prefix   = beat.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      p_ok  <= 1'b0;
      p     <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            lower <= start_ob;
            bound <= end_ob;
            p     <= '0;
            p_ok  <= 1'b1;
            if (start_ob <= end_ob) begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          if (p_ok) begin
            if (emit) begin
              if (out_free) begin
                if (done) begin
                  state <= IDLE;
                end else begin
                  lower <= filled + word_t'(1);
                  p_ok  <= 1'b0;
                end
              end
            end else begin
              p <= p + len_t'(1);
            end
          end else if (fit) begin
            p_ok <= 1'b1;
          end else begin
            p <= p - len_t'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/rtpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpc_checker
// Port-level checks of the range to prefix cover block, bound to the top.
// ----------------------------------------------------------------------------
module rtpc_checker import rtpc_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input field_t prefix_base,
  input len_t   prefix_length,
  input logic   last_prefix
);

  // a held beat is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // a held beat does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(prefix_base) && $stable(prefix_length)
      && $stable(last_prefix))
    else $error("output beat changed while stalled");

  // a non-final prefix means the range is still in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_prefix |-> in_stall)
    else $error("input taken before range cover finished");

  // prefix length never exceeds the word
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> prefix_length <= P_MAX)
    else $error("prefix length out of range");

endmodule

bind range_to_prefix_cover_core rtpc_checker u_rtpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .prefix_base   (prefix_base),
  .prefix_length (prefix_length),
  .last_prefix   (last_prefix)
);
